### hdl/rbpf_pkg.sv
package rbpf_pkg;

    // Fixed field widths
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int KEY_W     = 9;
    localparam int PIX_W     = 32;
    localparam int ADDR_W    = 24;
    localparam int IDX_W     = 8;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Rectangle sides saturate here
    localparam int MAX_DIM = 4096;

    // Default palette depth
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PITCH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_KEY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR  = 3'd7;

    // Blit modes
    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_INDEX = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    // Request kinds
    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PALETTE = 1'b1;

    localparam logic [KEY_W-1:0] KEY_NONE = 9'd256;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [DIM_W-1:0]   dest_pitch;
        logic [KEY_W-1:0]   color_key;
        logic [PIX_W-1:0]   fill_color;
    } t_cfg;

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_value;
        logic [7:0]       palette_index;
        logic [7:0]       palette_red;
        logic [7:0]       palette_green;
        logic [7:0]       palette_blue;
    } t_req;

    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] dest_address;
        logic [PIX_W-1:0]  dest_data;
        logic              last;
    } t_res;

    // Palette write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [RGB_W-1:0] rgb;
    } t_pal_wr;

endpackage

### hdl/rbpf_stream_if.sv
interface rbpf_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rbpf_pal.sv
module rbpf_pal #(
    parameter int ENTRIES = rbpf_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rbpf_pkg::t_pal_wr                  i_wr,
    input  logic                               i_rd_en,
    input  logic [rbpf_pkg::IDX_W-1:0]         i_rd_idx,
    output logic [rbpf_pkg::PIX_W-1:0]         o_rd_argb
);
    import rbpf_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [RGB_W-1:0]   mem [ENTRIES];
    logic [ENTRIES-1:0] r_seen;
    logic [RGB_W-1:0]   r_rd_rgb;
    logic               r_rd_hit;
    logic               wr_in_range;
    logic               rd_in_range;

    assign wr_in_range = ({1'b0, i_wr.idx} < (IDX_W+1)'(ENTRIES));
    assign rd_in_range = ({1'b0, i_rd_idx} < (IDX_W+1)'(ENTRIES));

    // Entry valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (i_wr.en && wr_in_range) begin
            r_seen[i_wr.idx[AW-1:0]] <= 1'b1;
        end
    end

    // RGB store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en && wr_in_range) begin
            mem[i_wr.idx[AW-1:0]] <= i_wr.rgb;
        end
        if (i_rd_en) begin
            r_rd_rgb <= mem[i_rd_idx[AW-1:0]];
        end
    end

    // Hit flag travels with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_hit <= rd_in_range && r_seen[i_rd_idx[AW-1:0]];
        end
    end

    // Unwritten entries read as all zero, no alpha
    assign o_rd_argb = r_rd_hit ? {ALPHA_OPAQUE, r_rd_rgb} : '0;

endmodule

### hdl/rbpf_walk.sv
module rbpf_walk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbpf_pkg::t_cfg                i_cfg,
    input  logic                          i_take,
    input  logic                          i_pixel,
    output logic                          o_span_ok,
    output logic [rbpf_pkg::ADDR_W-1:0]   o_addr,
    output logic                          o_last
);
    import rbpf_pkg::*;

    localparam logic [DIM_W+1:0] MAX_DIM_L = (DIM_W+2)'(MAX_DIM);

    logic [DIM_W-1:0]    r_col;
    logic [DIM_W-1:0]    r_row;
    logic [DIM_W-1:0]    n_col;
    logic [DIM_W-1:0]    n_row;
    logic [ADDR_W-1:0]   r_prod;
    logic [DIM_W:0]      r_xcol;
    logic                r_live;
    logic                r_last;

    logic [DIM_W-1:0]    w_sat;
    logic [DIM_W-1:0]    h_sat;
    logic                restart;
    logic [DIM_W-1:0]    col_e;
    logic [DIM_W-1:0]    row_e;
    logic [DIM_W-1:0]    col_inc;
    logic [DIM_W-1:0]    row_inc;
    logic                wrap_c;
    logic                wrap_r;
    logic [DIM_W:0]      ysum;
    logic [2*DIM_W:0]    prod;

    // Saturated rectangle sides
    assign w_sat = ({2'b00, i_cfg.rect_width} > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0]
                                                           : i_cfg.rect_width;
    assign h_sat = ({2'b00, i_cfg.rect_height} > MAX_DIM_L) ? MAX_DIM_L[DIM_W-1:0]
                                                            : i_cfg.rect_height;
    assign o_span_ok = (w_sat != '0) && (h_sat != '0);

    // Effective position and raster advance
    always_comb begin
        restart = (r_col >= w_sat) || (r_row >= h_sat);
        col_e   = restart ? '0 : r_col;
        row_e   = restart ? '0 : r_row;
        col_inc = col_e + DIM_W'(1);
        row_inc = row_e + DIM_W'(1);
        wrap_c  = (col_inc == w_sat);
        wrap_r  = (row_inc == h_sat);
        if (wrap_c) begin
            n_col = '0;
            n_row = wrap_r ? '0 : row_inc;
        end else begin
            n_col = col_inc;
            n_row = row_e;
        end
        ysum = (DIM_W+1)'(i_cfg.dest_y) + (DIM_W+1)'(row_e);
        prod = (2*DIM_W+1)'(ysum) * (2*DIM_W+1)'(i_cfg.dest_pitch);
    end

    // Position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_take && i_pixel && o_span_ok) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Row product and column offset for the accepted item
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_prod <= prod[ADDR_W-1:0];
            r_xcol <= (DIM_W+1)'(i_cfg.dest_x) + (DIM_W+1)'(col_e);
            r_live <= i_pixel && o_span_ok;
            r_last <= wrap_c && wrap_r;
        end
    end

    assign o_addr = r_live ? (r_prod + ADDR_W'(r_xcol)) : '0;
    assign o_last = r_live && r_last;

endmodule

### hdl/rect_blit_palette_fill_core.sv
// Channel   Modport  Payload  Moves
// i_req     sink     t_req    source pixel or palette entry, one transaction per item
// o_res     source   t_res    one destination write per item, in order
// i_cfg_*   plain    32 bits  register write, no handshake
//
// Sustains one transaction per cycle while the sink is ready; a result passes the
// registered palette memory read in the middle stage, then the output register.
// The row product is one 14x13 multiply, registered before the address add.
// Reset is synchronous; palette valid bits clear at once, no clearing sweep.
// A stalled output holds the output register and the middle stage; input
// ready drops only when both are full and the sink is not ready.
module rect_blit_palette_fill_core #(
    parameter int PALETTE_ENTRIES = rbpf_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rbpf_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    rbpf_stream_if.sink                       i_req,
    rbpf_stream_if.source                     o_res
);
    import rbpf_pkg::*;

    typedef enum logic [1:0] {
        K_ZERO,
        K_PIX,
        K_PAL,
        K_FILL
    } t_kind;

    t_cfg               r_cfg;
    logic               r_b_valid;
    t_kind              r_b_kind;
    logic               r_b_we;
    logic [PIX_W-1:0]   r_b_pix;
    logic               r_o_valid;
    t_res               r_o;

    t_req               req;
    logic               accept;
    logic               is_pixel;
    logic               b_move;
    logic               span_ok;
    logic [ADDR_W-1:0]  b_addr;
    logic               b_last;
    logic [PIX_W-1:0]   pal_argb;
    logic [PIX_W-1:0]   b_data;
    t_pal_wr            pal_wr;
    t_kind              a_kind;
    logic               a_we;

    assign req      = i_req.data;
    assign b_move   = r_b_valid && (!r_o_valid || o_res.ready);
    assign i_req.ready = !r_b_valid || b_move;
    assign accept   = i_req.valid && i_req.ready;
    assign is_pixel = (req.req_type == REQ_PIXEL);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{MODE_COPY, '0, '0, '0, '0, '0, KEY_NONE, '0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:        r_cfg.mode        <= i_cfg_data[1:0];
                CFG_DEST_X:      r_cfg.dest_x      <= i_cfg_data[COORD_W-1:0];
                CFG_DEST_Y:      r_cfg.dest_y      <= i_cfg_data[COORD_W-1:0];
                CFG_RECT_WIDTH:  r_cfg.rect_width  <= i_cfg_data[DIM_W-1:0];
                CFG_RECT_HEIGHT: r_cfg.rect_height <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_PITCH:  r_cfg.dest_pitch  <= i_cfg_data[DIM_W-1:0];
                CFG_COLOR_KEY:   r_cfg.color_key   <= i_cfg_data[KEY_W-1:0];
                CFG_FILL_COLOR:  r_cfg.fill_color  <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Palette store
    assign pal_wr.en  = accept && (req.req_type == REQ_PALETTE);
    assign pal_wr.idx = req.palette_index;
    assign pal_wr.rgb = {req.palette_red, req.palette_green, req.palette_blue};

    rbpf_pal #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_pal (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (pal_wr),
        .i_rd_en   (accept && is_pixel),
        .i_rd_idx  (req.pixel_value[IDX_W-1:0]),
        .o_rd_argb (pal_argb)
    );

    // Raster position and address
    rbpf_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_take    (accept),
        .i_pixel   (is_pixel),
        .o_span_ok (span_ok),
        .o_addr    (b_addr),
        .o_last    (b_last)
    );

    // Data source and write enable for the incoming item
    always_comb begin
        a_kind = K_ZERO;
        a_we   = 1'b0;
        if (is_pixel && span_ok) begin
            case (r_cfg.mode)
                MODE_COPY: begin
                    a_kind = K_PIX;
                    a_we   = 1'b1;
                end
                MODE_INDEX: begin
                    if ({1'b0, req.pixel_value[IDX_W-1:0]} != r_cfg.color_key) begin
                        a_kind = K_PAL;
                        a_we   = 1'b1;
                    end
                end
                MODE_FILL: begin
                    a_kind = K_FILL;
                    a_we   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Middle stage: waits on the palette read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_kind <= a_kind;
            r_b_we   <= a_we;
            r_b_pix  <= req.pixel_value;
        end
    end

    always_comb begin
        case (r_b_kind)
            K_PIX:   b_data = r_b_pix;
            K_PAL:   b_data = pal_argb;
            K_FILL:  b_data = r_cfg.fill_color;
            default: b_data = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_move) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_o.write_enable <= r_b_we;
            r_o.dest_address <= b_addr;
            r_o.dest_data    <= b_data;
            r_o.last         <= b_last;
        end
    end

    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_o;

    // An empty output register never blocks the input
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid |-> i_req.ready)
        else $error("input stalled with free output register");

    // A middle-stage item lands in the output register
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_move |=> r_o_valid)
        else $error("middle-stage transaction lost");

    // The middle stage only fills from an accepted transaction
    a_b_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_b_valid) |-> $past(accept))
        else $error("middle stage filled without a transaction");

endmodule
